/* rtl/psmt_pkg.sv */
package psmt_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned DIV_STEPS = DATA_W + 1;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic signed [DATA_W-1:0] PEAK_START_RST = 32'shFF9C_0000;
    localparam logic signed [DATA_W-1:0] MIN_START_RST  = 32'sh0064_0000;

    localparam logic [0:0] REG_PEAK_START = 1'b0;
    localparam logic [0:0] REG_MIN_START  = 1'b1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_RESET  = 1'b1;

endpackage

/* rtl/psmt_div.sv */
module psmt_div
    import psmt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W:0]   dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W:0]   quotient
);

    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    rem_next;
    logic [DATA_W:0]      quo_reg;
    logic [DATA_W:0]      quo_next;
    logic [DATA_W-1:0]    den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 run_reg;
    logic                 run_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W+1:0]    diff;
    logic                 fits;

    // One quotient bit per cycle, restoring form.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DATA_W]};
        diff      = {1'b0, shifted} - {2'b00, den_reg};
        fits      = !diff[DATA_W+1];
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-1:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/peak_min_max_slope_tracker.sv */
// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid / s_tready       tuser: command; tdata: time, value
// m_*       out        m_tvalid / m_tready       tdata: peak, min and slope with times
// cfg_*     in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A sample that yields a slope passes these steps before the next item is accepted:
// accept, 33 bit-serial divider steps, the divider's done flag,
// saturate and compare the slope, and load the result register.
// A reset command, a first sample or a non-positive time step goes from accept straight to loading the result register.
// Reset clears the control state and loads the start registers with their defaults.
// While the result register is full and not taken, the next result waits in place.
module peak_min_max_slope_tracker
    import psmt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2*DATA_W-1:0] s_tdata,   // sample_time, sample_value
    input  logic                s_tuser,   // command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [6*DATA_W-1:0] m_tdata,   // peak_value, peak_time, min_value, min_time,
                                           // max_slope, max_slope_time
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [DATA_W-1:0]   cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SLOPE,
        ST_OUT
    } state_t;

    state_t                    state_reg;
    logic signed [DATA_W-1:0]  peak_start_reg;
    logic signed [DATA_W-1:0]  min_start_reg;
    logic                      have_prev_reg;
    logic [DATA_W-1:0]         prev_time_reg;
    logic signed [DATA_W-1:0]  prev_value_reg;
    logic signed [DATA_W-1:0]  peak_reg;
    logic [DATA_W-1:0]         peak_time_reg;
    logic signed [DATA_W-1:0]  min_reg;
    logic [DATA_W-1:0]         min_time_reg;
    logic signed [DATA_W-1:0]  slope_reg;
    logic [DATA_W-1:0]         slope_time_reg;
    logic [DATA_W-1:0]         cur_time_reg;
    logic                      neg_reg;
    logic                      m_tvalid_reg;
    logic [6*DATA_W-1:0]       m_tdata_reg;

    logic                      in_accept;
    logic [DATA_W-1:0]         in_time;
    logic signed [DATA_W-1:0]  in_value;
    logic signed [DATA_W:0]    dv;
    logic [DATA_W:0]           dv_mag;
    logic [DATA_W-1:0]         dt;
    logic                      dt_pos;
    logic                      div_start;
    logic                      div_done;
    logic [DATA_W:0]           quotient;
    logic signed [DATA_W-1:0]  slope_sat;
    logic                      out_free;

    assign in_accept = s_tvalid && s_tready;
    assign in_time   = s_tdata[DATA_W-1:0];
    assign in_value  = $signed(s_tdata[2*DATA_W-1:DATA_W]);
    assign dv        = {in_value[DATA_W-1], in_value}
                       - {prev_value_reg[DATA_W-1], prev_value_reg};
    assign dv_mag    = dv[DATA_W] ? (DATA_W+1)'(-dv) : dv;
    assign dt        = in_time - prev_time_reg;
    assign dt_pos    = in_time > prev_time_reg;
    assign div_start = in_accept && (s_tuser == CMD_SAMPLE) && have_prev_reg && dt_pos;
    assign out_free  = !m_tvalid_reg || m_tready;

    psmt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dv_mag),
        .divisor  (dt),
        .done     (div_done),
        .quotient (quotient)
    );

    // Quotient magnitudes of 2^31 and above clip to the signed range.
    always_comb
    begin
        if (!neg_reg)
        begin
            slope_sat = (quotient[DATA_W] || quotient[DATA_W-1])
                        ? {1'b0, {(DATA_W-1){1'b1}}} : $signed(quotient[DATA_W-1:0]);
        end
        else
        begin
            slope_sat = (quotient[DATA_W] || quotient[DATA_W-1])
                        ? {1'b1, {(DATA_W-1){1'b0}}}
                        : $signed(-quotient[DATA_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            peak_start_reg <= PEAK_START_RST;
            min_start_reg  <= MIN_START_RST;
            have_prev_reg  <= 1'b0;
            prev_time_reg  <= '0;
            prev_value_reg <= '0;
            peak_reg       <= PEAK_START_RST;
            peak_time_reg  <= '0;
            min_reg        <= MIN_START_RST;
            min_time_reg   <= '0;
            slope_reg      <= '0;
            slope_time_reg <= '0;
            cur_time_reg   <= '0;
            neg_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_PEAK_START: peak_start_reg <= $signed(cfg_data);
                    REG_MIN_START:  min_start_reg  <= $signed(cfg_data);
                    default:        ;
                endcase
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (s_tuser == CMD_RESET)
                        begin
                            peak_reg  <= peak_start_reg;
                            min_reg   <= min_start_reg;
                            slope_reg <= '0;
                        end
                        else
                        begin
                            if (in_value > peak_reg)
                            begin
                                peak_reg      <= in_value;
                                peak_time_reg <= in_time;
                            end
                            if (in_value < min_reg)
                            begin
                                min_reg      <= in_value;
                                min_time_reg <= in_time;
                            end
                            prev_time_reg  <= in_time;
                            prev_value_reg <= in_value;
                            have_prev_reg  <= 1'b1;
                            cur_time_reg   <= in_time;
                            neg_reg        <= dv[DATA_W];
                        end
                        state_reg <= div_start ? ST_DIV : ST_OUT;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_SLOPE;
                    end
                end
                ST_SLOPE:
                begin
                    if (slope_sat > slope_reg)
                    begin
                        slope_reg      <= slope_sat;
                        slope_time_reg <= cur_time_reg;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {slope_time_reg, slope_reg, min_time_reg, min_reg,
                                         peak_time_reg, peak_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the division state");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_tready)
        else $error("item accepted while another is in work");

    a_reset_clears_slope: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s_tuser == CMD_RESET |=> slope_reg == '0 && state_reg == ST_OUT)
        else $error("reset command did not clear the slope");
`endif

endmodule
